// File: rtl/fpst_pkg.sv
`default_nettype none

package fpst_pkg;

	localparam int unsigned DEPTH_DEFAULT = 1024;

	localparam int unsigned FUNC_W = 2;
	localparam int unsigned IDX_W  = 11;
	localparam int unsigned VAL_W  = 16;
	localparam int unsigned SUM_W  = 32;

	// A climbing position can reach twice the largest index before it leaves the tree.
	localparam int unsigned POS_W  = IDX_W + 1;

	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned M_TDATA_W = 32;

	localparam logic [IDX_W-1:0] SIZE_RESET = IDX_W'(1024);

	typedef logic [FUNC_W-1:0] func_t;

	localparam func_t FUNC_ADD   = 2'd0;
	localparam func_t FUNC_QUERY = 2'd1;
	localparam func_t FUNC_CLEAR = 2'd2;

endpackage

`default_nettype wire

// File: rtl/fenwick_prefix_sum_table_top.sv
`default_nettype none

// Channel   Direction  Width  Contents
// cfg       in         11     size_in_use, written when cfg_we is high
// s_axis    in         32+2   tdata: index[10:0], value[26:11]; tuser: func
// m_axis    out        32     tdata: prefix_sum
//
// An add or a query visits k cells, k at most 11; an unused code goes straight to the done state.
// Each visited cell goes through the single read port of the cell memory and the shared 32-bit adder.
// A clear item sweeps the memory one cell a cycle and then presents its result.
// After reset the same sweep runs over every cell, during which no item is taken.
// The next transfer can be taken once the result is shown; a result held on m_axis does not stop it.

module fenwick_prefix_sum_table_top #(
	parameter int unsigned DEPTH = fpst_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpst_pkg::IDX_W-1:0]          cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fpst_pkg::S_TDATA_W-1:0]      s_tdata,   // index, value, zero fill
	input  logic [fpst_pkg::FUNC_W-1:0]         s_tuser,   // func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fpst_pkg::M_TDATA_W-1:0]      m_tdata    // prefix_sum
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned PW = fpst_pkg::POS_W;
	localparam int unsigned XW = (AW > PW) ? AW : PW;
	localparam int unsigned SW = fpst_pkg::SUM_W;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_QRY  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                   state_q;
	logic [fpst_pkg::IDX_W-1:0]   size_q;
	logic [AW-1:0]                clr_addr_q;
	logic                         clr_item_q;
	logic                         rd_pend_q;
	logic                         out_valid_q;
	logic [PW-1:0]                pos_q;
	logic [PW-1:0]                rd_pos_q;
	logic [SW-1:0]                acc_q;
	logic [SW-1:0]                amt_q;
	logic [SW-1:0]                res_q;
	logic [SW-1:0]                out_data_q;
	logic [SW-1:0]                rdata_q;
	logic [SW-1:0]                mem_q [DEPTH];

	fpst_pkg::func_t                     in_func;
	logic [fpst_pkg::IDX_W-1:0]          in_index;
	logic signed [fpst_pkg::VAL_W-1:0]   in_value;
	logic [PW-1:0]                       in_pos;
	logic                                accept_w;
	logic [PW-1:0]                       n_w;
	logic [PW-1:0]                       lsb_w;
	logic                                issue_w;
	logic                                walk_done_w;
	logic                                out_free_w;
	logic [XW-1:0]                       rpos_ext;
	logic [XW-1:0]                       wpos_ext;
	logic [AW-1:0]                       mem_raddr;
	logic [AW-1:0]                       mem_waddr;
	logic                                mem_we;
	logic [SW-1:0]                       mem_wdata;
	logic [SW-1:0]                       sum_w;

	assign in_func  = s_tuser;
	assign in_index = s_tdata[fpst_pkg::IDX_W-1:0];
	assign in_value = s_tdata[fpst_pkg::IDX_W +: fpst_pkg::VAL_W];
	assign in_pos   = PW'(in_index);

	assign s_tready   = (state_q == ST_IDLE);
	assign accept_w   = s_tvalid && s_tready;
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign out_free_w = !out_valid_q || m_tready;

	assign n_w   = (32'(size_q) > 32'(DEPTH)) ? PW'(DEPTH) : PW'(size_q);
	assign lsb_w = pos_q & (~pos_q + PW'(1));

	always_comb begin
		issue_w = 1'b0;
		case (state_q)
			ST_ADD:  issue_w = (pos_q != '0) && (pos_q <= n_w);
			ST_QRY:  issue_w = (pos_q != '0);
			default: issue_w = 1'b0;
		endcase
	end

	assign walk_done_w = !rd_pend_q && !issue_w;

	// The one adder serves both walks: cell plus amount on an add, running sum plus cell on a query.
	assign sum_w = ((state_q == ST_ADD) ? amt_q : acc_q) + rdata_q;

	assign rpos_ext  = XW'(pos_q) - XW'(1);
	assign wpos_ext  = XW'(rd_pos_q) - XW'(1);
	assign mem_raddr = rpos_ext[AW-1:0];
	assign mem_we    = (state_q == ST_CLR) || ((state_q == ST_ADD) && rd_pend_q);
	assign mem_waddr = (state_q == ST_CLR) ? clr_addr_q : wpos_ext[AW-1:0];
	assign mem_wdata = (state_q == ST_CLR) ? '0 : sum_w;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			size_q      <= fpst_pkg::SIZE_RESET;
			clr_addr_q  <= '0;
			clr_item_q  <= 1'b0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if ((state_q == ST_DONE) && out_free_w) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						clr_item_q <= 1'b0;
						state_q    <= clr_item_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					rd_pend_q <= 1'b0;
					if (accept_w) begin
						case (in_func)
							fpst_pkg::FUNC_ADD:   state_q <= ST_ADD;
							fpst_pkg::FUNC_QUERY: state_q <= ST_QRY;
							fpst_pkg::FUNC_CLEAR: begin
								clr_addr_q <= '0;
								clr_item_q <= 1'b1;
								state_q    <= ST_CLR;
							end
							default:              state_q <= ST_DONE;
						endcase
					end
				end
				ST_ADD, ST_QRY: begin
					rd_pend_q <= issue_w;
					if (walk_done_w) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free_w) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_CLR: begin
				res_q <= '0;
			end
			ST_IDLE: begin
				acc_q <= '0;
				res_q <= '0;
				amt_q <= SW'(in_value);
				pos_q <= (in_func == fpst_pkg::FUNC_QUERY && in_pos > n_w) ? n_w : in_pos;
			end
			ST_ADD: begin
				if (issue_w) begin
					pos_q    <= pos_q + lsb_w;
					rd_pos_q <= pos_q;
				end
				if (walk_done_w) begin
					res_q <= '0;
				end
			end
			ST_QRY: begin
				if (rd_pend_q) begin
					acc_q <= sum_w;
				end
				if (issue_w) begin
					pos_q <= pos_q - lsb_w;
				end
				if (walk_done_w) begin
					res_q <= acc_q;
				end
			end
			ST_DONE: begin
				if (out_free_w) begin
					out_data_q <= res_q;
				end
			end
			default: res_q <= '0;
		endcase
	end

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && issue_w) |-> (pos_q != '0 && pos_q <= n_w && PW'(DEPTH) != '0
			|| pos_q != '0 && pos_q <= n_w))
		else $error("Add walk reads a position outside the tree.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (state_q == ST_ADD || state_q == ST_QRY))
		else $error("Memory read pending outside a walk.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QRY && issue_w) |=> (pos_q < $past(pos_q)))
		else $error("Query walk does not descend.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && issue_w) |=> (pos_q > $past(pos_q)))
		else $error("Add walk does not climb.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE && !s_tready))
		else $error("Block still ready the cycle after a transfer.");
`endif

endmodule

`default_nettype wire

// File: bench/fenwick_checker.sv
`timescale 1ns / 1ps

module fenwick_checker #(
	parameter int unsigned DEPTH = fpst_pkg::DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fpst_pkg::IDX_W-1:0]     cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [fpst_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [fpst_pkg::FUNC_W-1:0]    s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [fpst_pkg::M_TDATA_W-1:0] m_tdata,
	output int unsigned                    mismatches,
	output int unsigned                    pending
);

	import fpst_pkg::*;

	logic [SUM_W-1:0] cells [1:DEPTH];
	logic [IDX_W-1:0] size_reg;
	logic [SUM_W-1:0] expected_sums [$];

	function automatic logic [SUM_W-1:0] fenwick_step(func_t func, logic [IDX_W-1:0] index,
			logic [VAL_W-1:0] value);
		int unsigned limit;
		int unsigned pos;
		logic [SUM_W-1:0] acc;
		limit = (size_reg > DEPTH) ? DEPTH : size_reg;
		pos = index;
		acc = '0;
		case (func)
			FUNC_ADD: begin
				while (pos != 0 && pos <= limit) begin
					cells[pos] = cells[pos] + {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
					pos = pos + (pos & (~pos + 1));
				end
			end
			FUNC_QUERY: begin
				if (pos > limit)
					pos = limit;
				while (pos != 0) begin
					acc = acc + cells[pos];
					pos = pos - (pos & (~pos + 1));
				end
			end
			FUNC_CLEAR: begin
				for (int i = 1; i <= DEPTH; i++)
					cells[i] = '0;
			end
			default: ;
		endcase
		return acc;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [SUM_W-1:0] want;
		if (!arst_n) begin
			for (int i = 1; i <= DEPTH; i++)
				cells[i] = '0;
			size_reg = SIZE_RESET;
			expected_sums.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				size_reg = cfg_wdata;
			if (s_tvalid && s_tready) begin
				want = fenwick_step(s_tuser, s_tdata[IDX_W-1:0], s_tdata[IDX_W +: VAL_W]);
				expected_sums = {expected_sums, want};
			end
			if (m_tvalid && m_tready) begin
				if (expected_sums.size() == 0) begin
					$display("%0t: prefix_sum transfer with nothing expected, actual %h",
						$realtime, m_tdata[SUM_W-1:0]);
					mismatches++;
				end else begin
					want = expected_sums.pop_front();
					if (m_tdata[SUM_W-1:0] !== want) begin
						$display("%0t: prefix_sum mismatch, expected %h, actual %h",
							$realtime, want, m_tdata[SUM_W-1:0]);
						mismatches++;
					end
				end
			end
			pending = expected_sums.size();
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import fpst_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned PHASE_ITEMS = 150;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned TAIL_CYCLES = 50;
	localparam func_t FUNC_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [FUNC_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	int unsigned          mismatches;
	int unsigned          pending;
	int unsigned          cycle_count = 0;

	always #5 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	fenwick_prefix_sum_table_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	fenwick_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	task automatic send_item(func_t func, logic [IDX_W-1:0] index, logic [VAL_W-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {{(S_TDATA_W-IDX_W-VAL_W){1'b0}}, value, index};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic hold_off(int unsigned cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_size(int unsigned size);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= IDX_W'(size);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic resize(int unsigned size);
		drain_results();
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		write_size(size);
	endtask

	function automatic logic [VAL_W-1:0] random_value();
		case ($urandom_range(0, 4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return VAL_W'(int'($urandom_range(0, 16)) - 8);
			default: return VAL_W'($urandom());
		endcase
	endfunction

	// Most items are adds and queries inside the tree; the rest probe the edges and noise.
	task automatic random_item(int unsigned limit, output bit counted);
		int unsigned pick;
		int unsigned index;
		func_t func;
		pick = $urandom_range(0, 99);
		counted = 1'b1;
		if (pick < 45) begin
			func = FUNC_ADD;
			index = $urandom_range(1, (limit == 0) ? 1 : limit);
		end else if (pick < 85) begin
			func = FUNC_QUERY;
			index = $urandom_range(0, limit);
		end else if (pick < 93) begin
			func = pick[0] ? FUNC_ADD : FUNC_QUERY;
			index = $urandom_range(0, (1 << IDX_W) - 1);
		end else if (pick < 95) begin
			func = FUNC_CLEAR;
			index = $urandom_range(0, (1 << IDX_W) - 1);
		end else begin
			func = pick[0] ? FUNC_UNUSED : FUNC_ADD;
			index = pick[0] ? $urandom_range(0, (1 << IDX_W) - 1) : 0;
			counted = 1'b0;
		end
		send_item(func, IDX_W'(index), random_value());
	endtask

	initial begin : receiver
		int unsigned mode;
		int unsigned span;
		m_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 7) == 0);
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[fenwick_prefix_sum_table_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned phase_sizes [9];
		int unsigned limit;
		int unsigned items;
		int unsigned burst_left;
		bit counted;
		phase_sizes = '{5, 0, 1, 2, 1024, 2047, 37, 300, 0};
		phase_sizes[8] = $urandom_range(1, (1 << IDX_W) - 1);
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = FUNC_ADD;
		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;

		write_size(1024);
		send_item(FUNC_ADD, 1, 16'h7FFF);
		send_item(FUNC_ADD, 1024, 16'h8000);
		send_item(FUNC_ADD, 0, 5);
		send_item(FUNC_ADD, 2047, 7);
		send_item(FUNC_ADD, 1025, 9);
		send_item(FUNC_ADD, 512, 1);
		send_item(FUNC_QUERY, 0, 16'hFFFF);
		send_item(FUNC_QUERY, 1, 0);
		send_item(FUNC_QUERY, 512, 0);
		send_item(FUNC_QUERY, 1023, 0);
		send_item(FUNC_QUERY, 1024, 0);
		send_item(FUNC_QUERY, 2047, 0);
		send_item(FUNC_UNUSED, 2047, 16'hFFFF);
		send_item(FUNC_QUERY, 1024, 0);
		send_item(FUNC_CLEAR, 0, 0);
		send_item(FUNC_QUERY, 1024, 0);
		send_item(FUNC_ADD, 3, 16'hFFFF);
		send_item(FUNC_QUERY, 3, 0);
		resize(0);
		send_item(FUNC_ADD, 1, 100);
		send_item(FUNC_QUERY, 1, 0);
		send_item(FUNC_QUERY, 2047, 0);
		resize(2047);
		send_item(FUNC_ADD, 1024, 16'hFFFF);
		send_item(FUNC_QUERY, 2047, 0);
		send_item(FUNC_QUERY, 1024, 0);

		burst_left = 0;
		foreach (phase_sizes[p]) begin
			resize(phase_sizes[p]);
			limit = (phase_sizes[p] > DEPTH_DEFAULT) ? DEPTH_DEFAULT : phase_sizes[p];
			items = 0;
			while (items < PHASE_ITEMS) begin
				if (burst_left == 0) begin
					if ($urandom_range(0, 2) != 0)
						hold_off($urandom_range(1, 12));
					burst_left = $urandom_range(1, 20);
				end
				burst_left--;
				if ($urandom_range(0, 199) == 0)
					drain_results();
				random_item(limit, counted);
				if (counted)
					items++;
			end
		end

		drain_results();
		repeat (TAIL_CYCLES)
			@(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("[fenwick_prefix_sum_table_top] OK");
		end else begin
			$display("[fenwick_prefix_sum_table_top] ERROR");
		end
		$finish;
	end

endmodule

// File: fenwick_prefix_sum_table_top.f
rtl/fpst_pkg.sv
rtl/fenwick_prefix_sum_table_top.sv
bench/fenwick_checker.sv
bench/testbench.sv
